>>> rtl/gfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types and constants of the group favoring lock arbiter.
// ----------------------------------------------------------------------------
package gfla_pkg;

   localparam int unsigned PCT_BASE  = 100;
   localparam logic [31:0] LCG_MUL   = 32'd1664525;
   localparam logic [31:0] LCG_ADD   = 32'd1013904223;
   // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for every 32-bit x
   localparam logic [31:0] PCT_RECIP = 32'h51EB851F;
   localparam int          PCT_SHIFT = 37;

   typedef enum logic [1:0] {
      REQ_CREATE  = 2'd0,
      REQ_DESTROY = 2'd1,
      REQ_ACQUIRE = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_BAD_IDX = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

endpackage

>>> rtl/gfla_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_req_if / gfla_rsp_if / gfla_csr_if
// Valid/ready channels of the lock arbiter.
// ----------------------------------------------------------------------------
interface gfla_req_if #(parameter int ID_WIDTH = 16, parameter int GROUP_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   logic [3:0]             lock_index;
   logic [ID_WIDTH-1:0]    requester_id;
   logic [GROUP_WIDTH-1:0] requester_group;
   logic [6:0]             favor_percent;
   modport source (output valid, req_type, lock_index, requester_id, requester_group,
                   favor_percent, input ready);
   modport sink (input valid, req_type, lock_index, requester_id, requester_group,
                 favor_percent, output ready);
endinterface

interface gfla_rsp_if #(parameter int ID_WIDTH = 16, parameter int GROUP_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [3:0]             created_index;
   logic                   granted;
   logic                   queued;
   logic [ID_WIDTH-1:0]    holder_id;
   logic [GROUP_WIDTH-1:0] holder_group;
   modport source (output valid, status, created_index, granted, queued, holder_id,
                   holder_group, input ready);
   modport sink (input valid, status, created_index, granted, queued, holder_id,
                 holder_group, output ready);
endinterface

interface gfla_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/gfla_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_front
// Accepts request beats and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module gfla_front #(
   parameter int ID_WIDTH    = 16,
   parameter int GROUP_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   gfla_req_if.sink               req,
   input  logic                   pop,
   output logic                   q_valid,
   output logic [1:0]             q_type,
   output logic [3:0]             q_index,
   output logic [ID_WIDTH-1:0]    q_id,
   output logic [GROUP_WIDTH-1:0] q_group,
   output logic [6:0]             q_favor
);
   import gfla_pkg::*;

   localparam int W = 2 + 4 + ID_WIDTH + GROUP_WIDTH + 7;

   logic [W-1:0] mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;
   logic [W-1:0] head;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign head      = mem_ff[rp_ff];
   assign {q_type, q_index, q_id, q_group, q_favor} = head;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = (pop && q_valid) ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= {req.req_type, req.lock_index, req.requester_id,
                           req.requester_group, req.favor_percent};
      end
   end
endmodule

>>> rtl/gfla_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfla_engine
// Sequencer over the slot table and the wait queue memory; one request at a time.
// ----------------------------------------------------------------------------
module gfla_engine #(
   parameter int NUM_LOCKS   = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16,
   parameter int GROUP_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  logic [1:0]             q_type,
   input  logic [3:0]             q_index,
   input  logic [ID_WIDTH-1:0]    q_id,
   input  logic [GROUP_WIDTH-1:0] q_group,
   input  logic [6:0]             q_favor,
   output logic                   pop,
   gfla_csr_if.sink               csr,
   gfla_rsp_if.source             rsp
);
   import gfla_pkg::*;

   localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_WIDTH + GROUP_WIDTH;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_MUL   = 10'b0000000100,
      S_DIV   = 10'b0000001000,
      S_MOD   = 10'b0000010000,
      S_SCAN  = 10'b0000100000,
      S_PICK  = 10'b0001000000,
      S_SHIFT = 10'b0010000000,
      S_SHW   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type            st_ff, st_in;
   logic [NUM_LOCKS-1:0] act_ff, lck_ff, ov_ff;
   logic [6:0]           fav_ff [NUM_LOCKS];
   logic [GROUP_WIDTH-1:0] og_ff [NUM_LOCKS];
   logic [CW-1:0]        tot_ff [NUM_LOCKS];
   logic [EW-1:0]        qmem [2**(LW+QW)];
   logic [EW-1:0]        rd_ff;
   logic [LW+QW-1:0]     raddr, waddr;
   logic                 we;
   logic [EW-1:0]        wdata;
   logic [31:0]          rng_ff, prod_ff, rem_ff;
   logic [63:0]          recip_ff;
   logic                 fav_hit_ff;
   logic [CW-1:0]        ptr_ff, pick_ff;
   logic                 found_ff;
   logic [LW-1:0]        li;
   logic                 rd_pend_ff;
   logic                 rv_ff;
   logic [1:0]           rs_ff;
   logic [3:0]           rc_ff;
   logic                 rg_ff, rq_ff;
   logic [ID_WIDTH-1:0]  rh_ff;
   logic [GROUP_WIDTH-1:0] rgp_ff;
   logic [CW-1:0]        n;
   logic [LW-1:0]        free_idx;
   logic                 free_any;

   assign li  = LW'(q_index);
   assign n   = tot_ff[li];
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.created_index = rc_ff;
   assign rsp.granted = rg_ff;
   assign rsp.queued = rq_ff;
   assign rsp.holder_id = rh_ff;
   assign rsp.holder_group = rgp_ff;
   assign pop = (st_ff == S_OUT) && !rv_ff;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_any = 1'b1;
            free_idx = LW'(i);
         end
      end
   end

   always_comb begin
      raddr = {li, ptr_ff[QW-1:0]};
      we    = 1'b0;
      waddr = {li, n[QW-1:0]};
      wdata = {q_id, q_group};
      st_in = st_ff;
      case (st_ff)
         S_IDLE:  if (q_valid && !rv_ff) st_in = S_DEC;
         S_DEC: begin
            if (q_type == REQ_RELEASE && {28'd0, q_index} < NUM_LOCKS && n != '0)
               st_in = S_MUL;
            else st_in = S_OUT;
            if (q_type == REQ_ACQUIRE && {28'd0, q_index} < NUM_LOCKS
                && (lck_ff[li] || n != '0) && n < CW'(QUEUE_DEPTH))
               we = 1'b1;
         end
         S_MUL:   st_in = S_DIV;
         S_DIV:   st_in = S_MOD;
         S_MOD:   if (rem_ff < 32'(PCT_BASE)) st_in = S_SCAN;
         S_SCAN:  if (!fav_hit_ff || found_ff || ptr_ff >= n) st_in = S_PICK;
         S_PICK:  if (!rd_pend_ff) st_in = S_SHIFT;
         S_SHIFT: begin
            raddr = {li, QW'(ptr_ff + 1'b1)};
            if (ptr_ff >= n) st_in = S_OUT;
            else st_in = S_SHW;
         end
         S_SHW: if (!rd_pend_ff) begin
            we    = 1'b1;
            waddr = {li, ptr_ff[QW-1:0]};
            wdata = rd_ff;
            st_in = S_SHIFT;
         end
         S_OUT:   if (!rv_ff) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_PICK) raddr = {li, pick_ff[QW-1:0]};
   end

   always_ff @(posedge clock) begin
      rd_ff <= qmem[raddr];
      if (we) qmem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         act_ff <= '0;
         lck_ff <= '0;
         ov_ff  <= '0;
         rng_ff <= 32'd1;
         rv_ff  <= 1'b0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            fav_ff[i] <= '0;
            tot_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         if (csr.valid) rng_ff <= csr.data;
         rd_pend_ff <= 1'b0;
         case (st_ff)
            S_DEC: begin
               rs_ff <= ST_OK; rc_ff <= '0; rg_ff <= 1'b0; rq_ff <= 1'b0;
               rh_ff <= '0; rgp_ff <= '0;
               if (q_type == REQ_CREATE) begin
                  if (!free_any) rs_ff <= ST_NO_SLOT;
                  else begin
                     act_ff[free_idx] <= 1'b1;
                     lck_ff[free_idx] <= 1'b0;
                     ov_ff[free_idx]  <= 1'b0;
                     tot_ff[free_idx] <= '0;
                     fav_ff[free_idx] <= (q_favor > 7'd100) ? 7'd100 : q_favor;
                     rc_ff <= 4'(free_idx);
                  end
               end else if ({28'd0, q_index} >= NUM_LOCKS) rs_ff <= ST_BAD_IDX;
               else if (q_type == REQ_DESTROY) act_ff[li] <= 1'b0;
               else if (q_type == REQ_ACQUIRE) begin
                  if (!lck_ff[li] && n == '0) begin
                     lck_ff[li] <= 1'b1; og_ff[li] <= q_group; ov_ff[li] <= 1'b1;
                     rg_ff <= 1'b1; rh_ff <= q_id; rgp_ff <= q_group;
                  end else if (n >= CW'(QUEUE_DEPTH)) rs_ff <= ST_FULL;
                  else begin
                     tot_ff[li] <= n + 1'b1; rq_ff <= 1'b1;
                  end
               end else if (n == '0) begin
                  lck_ff[li] <= 1'b0; ov_ff[li] <= 1'b0;
               end else begin
                  prod_ff <= rng_ff * LCG_MUL;
               end
            end
            S_MUL: begin
               rng_ff <= prod_ff + LCG_ADD;
               rem_ff <= prod_ff + LCG_ADD;
            end
            S_DIV: recip_ff <= {32'd0, rem_ff} * {32'd0, PCT_RECIP};
            S_MOD: begin
               if (rem_ff >= 32'(PCT_BASE))
                  rem_ff <= rem_ff
                            - 32'(recip_ff[63:PCT_SHIFT]) * 32'(PCT_BASE);
               else begin
                  fav_hit_ff <= (rem_ff[6:0] < fav_ff[li]) && ov_ff[li];
                  ptr_ff <= '0; pick_ff <= '0; found_ff <= 1'b0;
                  rd_pend_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               if (!rd_pend_ff && fav_hit_ff && !found_ff && ptr_ff < n) begin
                  if (rd_ff[GROUP_WIDTH-1:0] == og_ff[li]) begin
                     found_ff <= 1'b1; pick_ff <= ptr_ff;
                  end else begin
                     ptr_ff <= ptr_ff + 1'b1; rd_pend_ff <= 1'b1;
                  end
               end else if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
               end
               if (!(fav_hit_ff && !found_ff && ptr_ff < n)) rd_pend_ff <= 1'b1;
            end
            S_PICK: if (!rd_pend_ff) begin
               rg_ff <= 1'b1;
               rh_ff <= rd_ff[EW-1:GROUP_WIDTH];
               rgp_ff <= rd_ff[GROUP_WIDTH-1:0];
               lck_ff[li] <= 1'b1; ov_ff[li] <= 1'b1;
               og_ff[li] <= rd_ff[GROUP_WIDTH-1:0];
               tot_ff[li] <= n - 1'b1;
               ptr_ff <= pick_ff;
            end
            S_SHW: if (!rd_pend_ff) ptr_ff <= ptr_ff + 1'b1;
            S_OUT: if (!rv_ff) rv_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

>>> rtl/group_favoring_lock_arbiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_favoring_lock_arbiter_top
// Lock manager with per-lock FIFO wait queues and group favoring hand-over.
// ----------------------------------------------------------------------------
// One request at a time; a request starts only once the previous response beat
// has been taken. Release with waiters is the long case: its time grows with the
// queue length, and more so when a favored group scan finds no match. There
// the draw takes a multiply, the remainder a reciprocal multiply and a subtract,
// and the scan and the shift of the queue go through one read port of the wait
// queue memory.
module group_favoring_lock_arbiter_top #(
   parameter int NUM_LOCKS   = 16,
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16,
   parameter int GROUP_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   gfla_req_if.sink   req,
   gfla_rsp_if.source rsp,
   gfla_csr_if.sink   csr
);
   import gfla_pkg::*;

   logic                   pop, q_valid;
   logic [1:0]             q_type;
   logic [3:0]             q_index;
   logic [ID_WIDTH-1:0]    q_id;
   logic [GROUP_WIDTH-1:0] q_group;
   logic [6:0]             q_favor;

   gfla_front #(.ID_WIDTH(ID_WIDTH), .GROUP_WIDTH(GROUP_WIDTH)) u_front (
      .clock, .reset, .req, .pop, .q_valid, .q_type, .q_index, .q_id, .q_group, .q_favor);

   gfla_engine #(.NUM_LOCKS(NUM_LOCKS), .QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH),
                 .GROUP_WIDTH(GROUP_WIDTH)) u_engine (
      .clock, .reset, .q_valid, .q_type, .q_index, .q_id, .q_group, .q_favor, .pop,
      .csr, .rsp);
endmodule
